// ----- hw/rtl/irs_pkg.sv -----
// Shared types, constants and helpers for the image resampler.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package irs_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_CHANNELS = 4;
  localparam int FRAC_BITS    = 16;

  localparam int COL_W  = 8;
  localparam int ROW_W  = 8;
  localparam int CHAN_W = 2;
  localparam int PIX_W  = 16;
  localparam int STEP_W = 25;
  localparam int DIM_W  = 9;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int XW          = $clog2(MAX_WIDTH);
  localparam int YW          = $clog2(MAX_HEIGHT);

  localparam int PX_W  = COL_W + STEP_W;
  localparam int PY_W  = ROW_W + STEP_W;
  localparam int IX_W  = PX_W - FRAC_BITS;
  localparam int IY_W  = PY_W - FRAC_BITS;
  localparam int WGT_W = FRAC_BITS + 1;
  localparam int A_W   = PIX_W + FRAC_BITS;
  localparam int ACC_W = A_W + WGT_W;

  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_SAMPLE   = 1'b1;
  localparam logic MODE_NEAREST = 1'b0;
  localparam logic MODE_BILIN   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 3'd0,
    CFG_SRC_WIDTH  = 3'd1,
    CFG_SRC_HEIGHT = 3'd2,
    CFG_X_STEP     = 3'd3,
    CFG_Y_STEP     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CORNER_00 = 2'b00,
    CORNER_10 = 2'b01,
    CORNER_01 = 2'b10,
    CORNER_11 = 2'b11
  } corner_t;

  typedef enum logic [1:0] {
    MAC_A_PIX,
    MAC_A_TOP,
    MAC_A_BOT
  } mac_a_t;

  typedef enum logic [1:0] {
    MAC_B_WX0,
    MAC_B_WX1,
    MAC_B_WY0,
    MAC_B_WY1
  } mac_b_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_NEAR,
    RES_BLEND
  } res_sel_t;

  typedef struct packed {
    logic     take;
    logic     idx_load;
    logic     rd_en;
    corner_t  rd_corner;
    logic     mac_en;
    logic     mac_clr;
    mac_a_t   mac_a;
    mac_b_t   mac_b;
    logic     save_top;
    logic     save_bot;
    logic     out_load;
    res_sel_t res_sel;
  } irs_cmd_t;

  typedef struct packed {
    logic near;
    logic chan_bad;
  } irs_stat_t;

  function automatic logic [ADDR_W-1:0] frame_addr(input logic [XW-1:0] x,
                                                   input logic [YW-1:0] y,
                                                   input logic [CHAN_W-1:0] c);
    return (ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x)) * ADDR_W'(MAX_CHANNELS)
           + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/image_resampler_nearest_bilinear_unit.sv -----
// Image resampler top level: frame memory load and nearest or bilinear sampling.
// A load is written while the controller is idle. A sample steps through the index, read
// and blend states to the output state (nearest mode right after the first read); the input
// is stalled meanwhile, for the four reads of the single-port frame memory and the shared MAC.
// Synchronous active-low reset restores the register defaults; frame memory is not cleared.
`default_nettype none

module image_resampler_nearest_bilinear_unit
  import irs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_req_type,
  input  wire logic [COL_W-1:0]      in_col,
  input  wire logic [ROW_W-1:0]      in_row,
  input  wire logic [CHAN_W-1:0]     in_chan,
  input  wire logic [PIX_W-1:0]      in_pixel_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [PIX_W-1:0]      out_pixel_out
);

  irs_cmd_t  cmd;
  irs_stat_t stat;

  irs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  irs_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_req_type  (in_req_type),
    .in_col       (in_col),
    .in_row       (in_row),
    .in_chan      (in_chan),
    .in_pixel_in  (in_pixel_in),
    .out_pixel_out(out_pixel_out),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/irs_ram.sv -----
// Generic single-port RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module irs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/irs_ctrl.sv -----
// Sequencing state machine of the image resampler.
// Drives datapath commands from irs_pkg types and owns the channel handshakes.
`default_nettype none

module irs_ctrl
  import irs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_req_type,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire irs_stat_t stat,
  output irs_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDX,
    ST_R0,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_B1,
    ST_B2,
    ST_B3,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && (in_req_type == REQ_SAMPLE)) begin
          state_nxt = ST_IDX;
        end
      end
      ST_IDX: begin
        cmd.idx_load = 1'b1;
        state_nxt    = stat.chan_bad ? ST_OUT : ST_R0;
      end
      ST_R0: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_corner = CORNER_00;
        state_nxt     = stat.near ? ST_OUT : ST_R1;
      end
      ST_R1: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_corner = CORNER_10;
        cmd.mac_en    = 1'b1;
        cmd.mac_clr   = 1'b1;
        cmd.mac_a     = MAC_A_PIX;
        cmd.mac_b     = MAC_B_WX0;
        state_nxt     = ST_R2;
      end
      ST_R2: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_corner = CORNER_01;
        cmd.mac_en    = 1'b1;
        cmd.mac_a     = MAC_A_PIX;
        cmd.mac_b     = MAC_B_WX1;
        state_nxt     = ST_R3;
      end
      ST_R3: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_corner = CORNER_11;
        cmd.save_top  = 1'b1;
        cmd.mac_en    = 1'b1;
        cmd.mac_clr   = 1'b1;
        cmd.mac_a     = MAC_A_PIX;
        cmd.mac_b     = MAC_B_WX0;
        state_nxt     = ST_B1;
      end
      ST_B1: begin
        cmd.mac_en = 1'b1;
        cmd.mac_a  = MAC_A_PIX;
        cmd.mac_b  = MAC_B_WX1;
        state_nxt  = ST_B2;
      end
      ST_B2: begin
        cmd.save_bot = 1'b1;
        cmd.mac_en   = 1'b1;
        cmd.mac_clr  = 1'b1;
        cmd.mac_a    = MAC_A_TOP;
        cmd.mac_b    = MAC_B_WY0;
        state_nxt    = ST_B3;
      end
      ST_B3: begin
        cmd.mac_en = 1'b1;
        cmd.mac_a  = MAC_A_BOT;
        cmd.mac_b  = MAC_B_WY1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (stat.chan_bad) begin
          cmd.res_sel = RES_ZERO;
        end else if (stat.near) begin
          cmd.res_sel = RES_NEAR;
        end else begin
          cmd.res_sel = RES_BLEND;
        end
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- hw/rtl/irs_datapath.sv -----
// Datapath of the image resampler: configuration registers, position and
// clamp logic, frame memory, blend multiply-accumulate and output register.
// Depends on irs_pkg and irs_ram.
`default_nettype none

module irs_datapath
  import irs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_req_type,
  input  wire logic [COL_W-1:0]      in_col,
  input  wire logic [ROW_W-1:0]      in_row,
  input  wire logic [CHAN_W-1:0]     in_chan,
  input  wire logic [PIX_W-1:0]      in_pixel_in,
  output logic      [PIX_W-1:0]      out_pixel_out,
  input  wire irs_cmd_t              cmd,
  output irs_stat_t                  stat
);

  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (2 * FRAC_BITS - 1);
  localparam logic [WGT_W-1:0] ONE      = WGT_W'(1) << FRAC_BITS;
  localparam int               Q_W      = ACC_W - 2 * FRAC_BITS;

  logic              mode_r;
  logic [DIM_W-1:0]  src_width_r;
  logic [DIM_W-1:0]  src_height_r;
  logic [STEP_W-1:0] x_step_r;
  logic [STEP_W-1:0] y_step_r;

  logic [CHAN_W-1:0]    chan_r;
  logic [PX_W-1:0]      px_r;
  logic [PY_W-1:0]      py_r;
  logic [XW-1:0]        x0_r, x1_r, x0_nxt, x1_nxt;
  logic [YW-1:0]        y0_r, y1_r, y0_nxt, y1_nxt;
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic [A_W-1:0]       top_r, bot_r;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [PIX_W-1:0]     out_pixel_r, out_pixel_nxt;

  logic [XW-1:0]     wm1;
  logic [YW-1:0]     hm1;
  logic [IX_W-1:0]   xi;
  logic [IX_W:0]     xi_p1;
  logic [IY_W-1:0]   yi;
  logic [IY_W:0]     yi_p1;
  logic [A_W-1:0]    mac_a;
  logic [WGT_W-1:0]  mac_b;
  logic [ACC_W-1:0]  prod;
  logic [ACC_W-1:0]  rnd;
  logic [Q_W-1:0]    q;
  logic              load_ok;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_BILIN;
      src_width_r  <= DIM_W'(256);
      src_height_r <= DIM_W'(256);
      x_step_r     <= STEP_W'(65536);
      y_step_r     <= STEP_W'(65536);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:       mode_r       <= cfg_wdata[0];
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_X_STEP:     x_step_r     <= cfg_wdata[STEP_W-1:0];
        CFG_Y_STEP:     y_step_r     <= cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (src_width_r == '0) begin
      wm1 = '0;
    end else if (32'(src_width_r) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(src_width_r - 1'b1);
    end
    if (src_height_r == '0) begin
      hm1 = '0;
    end else if (32'(src_height_r) > MAX_HEIGHT) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(src_height_r - 1'b1);
    end
  end

  assign xi    = px_r[PX_W-1:FRAC_BITS];
  assign yi    = py_r[PY_W-1:FRAC_BITS];
  assign xi_p1 = {1'b0, xi} + 1'b1;
  assign yi_p1 = {1'b0, yi} + 1'b1;

  assign x0_nxt = (xi > IX_W'(wm1)) ? wm1 : XW'(xi);
  assign x1_nxt = (xi_p1 > (IX_W + 1)'(wm1)) ? wm1 : XW'(xi_p1);
  assign y0_nxt = (yi > IY_W'(hm1)) ? hm1 : YW'(yi);
  assign y1_nxt = (yi_p1 > (IY_W + 1)'(hm1)) ? hm1 : YW'(yi_p1);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      chan_r <= in_chan;
      px_r   <= PX_W'(in_col) * PX_W'(x_step_r);
      py_r   <= PY_W'(in_row) * PY_W'(y_step_r);
    end
    if (cmd.idx_load) begin
      x0_r <= x0_nxt;
      x1_r <= x1_nxt;
      y0_r <= y0_nxt;
      y1_r <= y1_nxt;
      fx_r <= px_r[FRAC_BITS-1:0];
      fy_r <= py_r[FRAC_BITS-1:0];
    end
  end

  assign load_ok = (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT) &&
                   (32'(in_chan) < MAX_CHANNELS);
  assign ram_we  = cmd.take && (in_req_type == REQ_LOAD) && load_ok;

  always_comb begin
    case (cmd.rd_corner)
      CORNER_00: rd_addr = frame_addr(x0_r, y0_r, chan_r);
      CORNER_10: rd_addr = frame_addr(x1_r, y0_r, chan_r);
      CORNER_01: rd_addr = frame_addr(x0_r, y1_r, chan_r);
      CORNER_11: rd_addr = frame_addr(x1_r, y1_r, chan_r);
      default:   rd_addr = frame_addr(x0_r, y0_r, chan_r);
    endcase
  end

  assign ram_addr = cmd.take ? frame_addr(XW'(in_col), YW'(in_row), in_chan) : rd_addr;

  irs_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (cmd.rd_en),
    .addr (ram_addr),
    .wdata(in_pixel_in),
    .rdata(ram_rdata)
  );

  always_comb begin
    case (cmd.mac_a)
      MAC_A_PIX: mac_a = A_W'(ram_rdata);
      MAC_A_TOP: mac_a = top_r;
      MAC_A_BOT: mac_a = bot_r;
      default:   mac_a = A_W'(ram_rdata);
    endcase
    case (cmd.mac_b)
      MAC_B_WX0: mac_b = ONE - WGT_W'(fx_r);
      MAC_B_WX1: mac_b = WGT_W'(fx_r);
      MAC_B_WY0: mac_b = ONE - WGT_W'(fy_r);
      MAC_B_WY1: mac_b = WGT_W'(fy_r);
      default:   mac_b = WGT_W'(fx_r);
    endcase
  end

  assign prod    = ACC_W'(mac_a) * ACC_W'(mac_b);
  assign acc_nxt = (cmd.mac_clr ? '0 : acc_r) + prod;

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.save_top) begin
      top_r <= acc_r[A_W-1:0];
    end
    if (cmd.save_bot) begin
      bot_r <= acc_r[A_W-1:0];
    end
  end

  assign rnd = acc_r + RND_HALF;
  assign q   = rnd[ACC_W-1:2*FRAC_BITS];

  always_comb begin
    case (cmd.res_sel)
      RES_ZERO:  out_pixel_nxt = '0;
      RES_NEAR:  out_pixel_nxt = ram_rdata;
      RES_BLEND: out_pixel_nxt = (q > Q_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : PIX_W'(q);
      default:   out_pixel_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel_r <= out_pixel_nxt;
    end
  end

  assign out_pixel_out = out_pixel_r;
  assign stat.near     = (mode_r == MODE_NEAREST);
  assign stat.chan_bad = ({1'b0, chan_r} >= (CHAN_W + 1)'(MAX_CHANNELS));

endmodule

`default_nettype wire

// ----- bench/tb_image_resampler_nearest_bilinear_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the image resampler: loads source pixels, samples them in
// nearest and bilinear mode and checks every result transfer against an in-bench predictor
// or a fixed expected value. Depends on irs_pkg and on the image_resampler_nearest_bilinear_unit top level only.

module tb_image_resampler_nearest_bilinear_unit;
  import irs_pkg::*;

  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 160;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic                  is_cfg;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  req;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic [CHAN_W-1:0]     chan;
    logic [PIX_W-1:0]      pix;
    logic                  typed;
    logic [PIX_W-1:0]      want;
  } stim_row_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  in_req_type = REQ_LOAD;
  logic [COL_W-1:0]      in_col      = '0;
  logic [ROW_W-1:0]      in_row      = '0;
  logic [CHAN_W-1:0]     in_chan     = '0;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [PIX_W-1:0]      out_pixel_out;

  logic                  cur_mode;
  logic [DIM_W-1:0]      cur_src_w;
  logic [DIM_W-1:0]      cur_src_h;
  logic [STEP_W-1:0]     cur_x_step;
  logic [STEP_W-1:0]     cur_y_step;
  logic [PIX_W-1:0]      frame_mem [int];
  bit                    loaded_set [int];
  logic [PIX_W:0]        note_q [$];
  logic [PIX_W-1:0]      pixel_exp_q [$];
  stim_row_t             dir_tab [$];

  int err_cnt     = 0;
  int items_sent  = 0;
  int idle_cycles = 0;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit rx_hold     = 1'b0;

  image_resampler_nearest_bilinear_unit i_dut (.*);

  always #4 clk = ~clk;

  function automatic int pix_slot(input int unsigned x, input int unsigned y,
                                  input int unsigned ch);
    return int'((y * MAX_WIDTH + x) * MAX_CHANNELS + ch);
  endfunction

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned clamp_idx(input longint unsigned v, input int unsigned dim);
    return (v > dim - 1) ? dim - 1 : v[31:0];
  endfunction

  function automatic void src_corners(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                                      output int unsigned x0, output int unsigned x1,
                                      output int unsigned y0, output int unsigned y1,
                                      output longint unsigned fx, output longint unsigned fy);
    longint unsigned px;
    longint unsigned py;
    int unsigned     w;
    int unsigned     h;
    w  = eff_dim(cur_src_w, MAX_WIDTH);
    h  = eff_dim(cur_src_h, MAX_HEIGHT);
    px = 64'(c) * 64'(cur_x_step);
    py = 64'(r) * 64'(cur_y_step);
    fx = px & ((64'd1 << FRAC_BITS) - 1);
    fy = py & ((64'd1 << FRAC_BITS) - 1);
    x0 = clamp_idx(px >> FRAC_BITS, w);
    y0 = clamp_idx(py >> FRAC_BITS, h);
    x1 = clamp_idx((px >> FRAC_BITS) + 1, w);
    y1 = clamp_idx((py >> FRAC_BITS) + 1, h);
  endfunction

  function automatic longint unsigned stored(input int unsigned x, input int unsigned y,
                                             input int unsigned ch);
    int a;
    a = pix_slot(x, y, ch);
    return frame_mem.exists(a) ? 64'(frame_mem[a]) : 64'd0;
  endfunction

  function automatic logic [PIX_W-1:0] resample_pixel(input logic [COL_W-1:0] c,
                                                      input logic [ROW_W-1:0] r,
                                                      input logic [CHAN_W-1:0] ch);
    int unsigned     x0;
    int unsigned     x1;
    int unsigned     y0;
    int unsigned     y1;
    longint unsigned fx;
    longint unsigned fy;
    longint unsigned one;
    longint unsigned top;
    longint unsigned bot;
    longint unsigned sum;
    src_corners(c, r, x0, x1, y0, y1, fx, fy);
    if (cur_mode == MODE_NEAREST) return PIX_W'(stored(x0, y0, ch));
    one = 64'd1 << FRAC_BITS;
    top = stored(x0, y0, ch) * (one - fx) + stored(x1, y0, ch) * fx;
    bot = stored(x0, y1, ch) * (one - fx) + stored(x1, y1, ch) * fx;
    sum = top * (one - fy) + bot * fy;
    sum = (sum + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    return (sum > 64'hFFFF) ? 16'hFFFF : sum[PIX_W-1:0];
  endfunction

  function automatic void report_fail(input string what, input logic [PIX_W-1:0] want,
                                      input logic [PIX_W-1:0] got);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) begin
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_pix();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim(input int unsigned lim);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DIM_W'(lim);
      2: return DIM_W'($urandom_range(lim + 1, 511));
      3: return DIM_W'($urandom_range(13, lim));
      default: return DIM_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return STEP_W'($urandom);
      3: return STEP_W'($urandom_range(1, 4)) << FRAC_BITS;
      default: return STEP_W'($urandom_range(32'h2000, 32'h30000));
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    stim_row_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = v;
    return s;
  endfunction

  function automatic stim_row_t load_row(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                                         input logic [CHAN_W-1:0] ch,
                                         input logic [PIX_W-1:0] pix);
    stim_row_t s;
    s      = '0;
    s.req  = REQ_LOAD;
    s.col  = c;
    s.row  = r;
    s.chan = ch;
    s.pix  = pix;
    return s;
  endfunction

  function automatic stim_row_t smp_row(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                                        input logic [CHAN_W-1:0] ch, input logic typed,
                                        input logic [PIX_W-1:0] want);
    stim_row_t s;
    s       = '0;
    s.req   = REQ_SAMPLE;
    s.col   = c;
    s.row   = r;
    s.chan  = ch;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:       cur_mode   = v[0];
      CFG_SRC_WIDTH:  cur_src_w  = v[DIM_W-1:0];
      CFG_SRC_HEIGHT: cur_src_h  = v[DIM_W-1:0];
      CFG_X_STEP:     cur_x_step = v[STEP_W-1:0];
      CFG_Y_STEP:     cur_y_step = v[STEP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drive_item(input logic req, input logic [COL_W-1:0] c,
                            input logic [ROW_W-1:0] r, input logic [CHAN_W-1:0] ch,
                            input logic [PIX_W-1:0] pix, input logic typed,
                            input logic [PIX_W-1:0] want);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_col      <= c;
    in_row      <= r;
    in_chan     <= ch;
    in_pixel_in <= pix;
    note_q.push_back({typed, want});
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic send_load(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                           input logic [CHAN_W-1:0] ch, input logic [PIX_W-1:0] pix);
    loaded_set[pix_slot(c, r, ch)] = 1'b1;
    drive_item(REQ_LOAD, c, r, ch, pix, 1'b0, '0);
  endtask

  // Every source entry that the sample will read gets loaded first, so no
  // never-written entry of the frame memory is ever read.
  task automatic send_sample(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                             input logic [CHAN_W-1:0] ch, input logic typed,
                             input logic [PIX_W-1:0] want);
    int unsigned     x0;
    int unsigned     x1;
    int unsigned     y0;
    int unsigned     y1;
    int unsigned     xx;
    int unsigned     yy;
    longint unsigned fx;
    longint unsigned fy;
    src_corners(c, r, x0, x1, y0, y1, fx, fy);
    for (int k = 0; k < 4; k++) begin
      xx = k[0] ? x1 : x0;
      yy = k[1] ? y1 : y0;
      if (!loaded_set.exists(pix_slot(xx, yy, ch))) begin
        send_load(COL_W'(xx), ROW_W'(yy), ch, rand_pix());
      end
    end
    drive_item(REQ_SAMPLE, c, r, ch, PIX_W'($urandom), typed, want);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (note_q.size() != 0 || pixel_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    logic [PIX_W:0]   note;
    logic [PIX_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_exp_q.size() == 0) begin
        report_fail("result transfer with nothing expected", 'x, out_pixel_out);
      end else begin
        want = pixel_exp_q.pop_front();
        if (out_pixel_out !== want) report_fail("pixel_out mismatch", want, out_pixel_out);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      note = note_q.pop_front();
      if (in_req_type == REQ_LOAD) begin
        frame_mem[pix_slot(in_col, in_row, in_chan)] = in_pixel_in;
      end else begin
        want = resample_pixel(in_col, in_row, in_chan);
        pixel_exp_q.push_back(note[PIX_W] ? note[PIX_W-1:0] : want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[image_resampler_nearest_bilinear_unit] ERROR");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        rx_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int stop_at;
    int span;
    bit paused;
    cur_mode   = MODE_BILIN;
    cur_src_w  = DIM_W'(MAX_WIDTH);
    cur_src_h  = DIM_W'(MAX_HEIGHT);
    cur_x_step = STEP_W'(1) << FRAC_BITS;
    cur_y_step = STEP_W'(1) << FRAC_BITS;

    // Register defaults first, then half steps, nearest mode, degenerate and oversized
    // sizes, the largest and zero steps, and a tiny image.
    dir_tab.push_back(load_row(8'd0, 8'd0, 2'd0, 16'hFFFF));
    dir_tab.push_back(load_row(8'd255, 8'd255, 2'd3, 16'h1234));
    dir_tab.push_back(load_row(8'd1, 8'd0, 2'd0, 16'h0000));
    dir_tab.push_back(load_row(8'd0, 8'd1, 2'd0, 16'h0000));
    dir_tab.push_back(load_row(8'd1, 8'd1, 2'd0, 16'h8000));
    dir_tab.push_back(smp_row(8'd0, 8'd0, 2'd0, 1'b1, 16'hFFFF));
    dir_tab.push_back(smp_row(8'd255, 8'd255, 2'd3, 1'b1, 16'h1234));
    dir_tab.push_back(cfg_row(CFG_X_STEP, 25'h0008000));
    dir_tab.push_back(cfg_row(CFG_Y_STEP, 25'h0008000));
    dir_tab.push_back(smp_row(8'd1, 8'd1, 2'd0, 1'b0, '0));
    dir_tab.push_back(smp_row(8'd255, 8'd255, 2'd3, 1'b0, '0));
    dir_tab.push_back(cfg_row(CFG_MODE, 25'(MODE_NEAREST)));
    dir_tab.push_back(smp_row(8'd1, 8'd1, 2'd0, 1'b1, 16'hFFFF));
    dir_tab.push_back(cfg_row(CFG_SRC_WIDTH, 25'd0));
    dir_tab.push_back(cfg_row(CFG_SRC_HEIGHT, 25'd0));
    dir_tab.push_back(cfg_row(CFG_X_STEP, 25'h1FFFFFF));
    dir_tab.push_back(cfg_row(CFG_Y_STEP, 25'h1FFFFFF));
    dir_tab.push_back(smp_row(8'd200, 8'd7, 2'd0, 1'b1, 16'hFFFF));
    dir_tab.push_back(cfg_row(CFG_SRC_WIDTH, 25'd511));
    dir_tab.push_back(cfg_row(CFG_SRC_HEIGHT, 25'd511));
    dir_tab.push_back(smp_row(8'd255, 8'd255, 2'd3, 1'b1, 16'h1234));
    dir_tab.push_back(cfg_row(CFG_MODE, 25'(MODE_BILIN)));
    dir_tab.push_back(smp_row(8'd255, 8'd255, 2'd3, 1'b1, 16'h1234));
    dir_tab.push_back(cfg_row(CFG_X_STEP, 25'd0));
    dir_tab.push_back(cfg_row(CFG_Y_STEP, 25'd0));
    dir_tab.push_back(smp_row(8'd9, 8'd9, 2'd0, 1'b1, 16'hFFFF));
    dir_tab.push_back(cfg_row(CFG_SRC_WIDTH, 25'd2));
    dir_tab.push_back(cfg_row(CFG_SRC_HEIGHT, 25'd2));
    dir_tab.push_back(cfg_row(CFG_X_STEP, 25'h0010000));
    dir_tab.push_back(cfg_row(CFG_Y_STEP, 25'h0010000));
    dir_tab.push_back(smp_row(8'd5, 8'd5, 2'd0, 1'b1, 16'h8000));
    dir_tab.push_back(smp_row(8'd0, 8'd1, 2'd2, 1'b0, '0));
    dir_tab.push_back(load_row(8'd0, 8'd0, 2'd0, 16'h0000));
    dir_tab.push_back(smp_row(8'd0, 8'd0, 2'd0, 1'b1, 16'h0000));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_drained();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else if (dir_tab[i].req == REQ_LOAD) begin
        send_load(dir_tab[i].col, dir_tab[i].row, dir_tab[i].chan, dir_tab[i].pix);
      end else begin
        send_sample(dir_tab[i].col, dir_tab[i].row, dir_tab[i].chan, dir_tab[i].typed,
                    dir_tab[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      tx_idle_on = (p != PHASES - 1) && ($urandom_range(0, 4) != 0);
      rx_idle_on = (p != PHASES - 1) && ($urandom_range(0, 4) != 0);
      write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(rand_dim(MAX_WIDTH)));
      write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(rand_dim(MAX_HEIGHT)));
      write_reg(CFG_X_STEP, CFG_DATA_W'(rand_step()));
      write_reg(CFG_Y_STEP, CFG_DATA_W'(rand_step()));
      case ($urandom_range(0, 2))
        0: span = 4;
        1: span = 32;
        default: span = 256;
      endcase
      // Hold the result side off long enough for the block to back up its input.
      if (p == 1) rx_hold = 1'b1;
      paused  = 1'b0;
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        if (p == 4 && !paused && items_sent >= stop_at - PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 6) == 0) begin
          send_load(COL_W'($urandom), ROW_W'($urandom), CHAN_W'($urandom), rand_pix());
        end else begin
          send_sample(COL_W'($urandom_range(0, span - 1)), ROW_W'($urandom_range(0, span - 1)),
                      CHAN_W'($urandom), 1'b0, '0);
        end
      end
    end

    wait_drained();
    if (err_cnt == 0 && pixel_exp_q.size() == 0) begin
      $display("[image_resampler_nearest_bilinear_unit] OK");
    end else begin
      $display("[image_resampler_nearest_bilinear_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/irs_pkg.sv
hw/rtl/irs_ram.sv
hw/rtl/irs_ctrl.sv
hw/rtl/irs_datapath.sv
hw/rtl/image_resampler_nearest_bilinear_unit.sv
bench/tb_image_resampler_nearest_bilinear_unit.sv
